// File: hdl/ffsa_pkg.sv
// shared types and constants of the first-fit sub-allocator
package ffsa_pkg;

  localparam int MAX_ALLOCS_DEF = 64;
  localparam int MAX_BUFFERS = 8;
  localparam int BUF_W = 3;
  localparam int NB_W = 4;

  localparam logic [1:0] CMD_ALLOC = 2'd0;
  localparam logic [1:0] CMD_FREE  = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NO_SPACE = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_NOTFOUND = 3'd3;
  localparam logic [2:0] ST_PENDING  = 3'd4;

  localparam logic [1:0] REG_INIT_BUFS = 2'd0;
  localparam logic [1:0] REG_BUF_BYTES = 2'd1;
  localparam logic [1:0] REG_FREE_DLY  = 2'd2;
  localparam logic [1:0] REG_CAN_GROW  = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_SCAN,
    S_PLACE,
    S_TICK,
    S_COMPACT,
    S_FINISH
  } state_t;

  typedef enum logic [2:0] {
    C_HOLD,
    C_ROT,
    C_INS,
    C_MARK,
    C_COMP
  } cell_op_t;

  typedef struct packed {
    logic             valid;
    logic             pending;
    logic [2:0]       frames;
    logic [BUF_W-1:0] buf_idx;
    logic [31:0]      off;
    logic [31:0]      len;
  } entry_t;

  typedef struct packed {
    cell_op_t         op;
    entry_t           ent;
    logic [BUF_W-1:0] key_buf;
    logic [31:0]      key_off;
    logic [2:0]       free_delay;
  } cell_ctl_t;

endpackage

// File: hdl/first_fit_suballocator_deferred_free.sv
// allocate: one table rotation with stalls
// free: parallel match in every cell
// frame tick: one table rotation, then compaction until the table has no holes
// one item at a time; the next is taken once its result sits in the output register
// synchronous reset empties the table, zeroes the total and sets one active buffer
module first_fit_suballocator_deferred_free #(
  parameter int MAX_ALLOCS = ffsa_pkg::MAX_ALLOCS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,  // req_size, buf_index, start_req
  input  logic [1:0]  s_tuser,  // cmd
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [87:0] m_tdata,  // status, alloc_buffer, alloc_start, grew, freed_count, in_use_bytes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import ffsa_pkg::*;

  localparam int RW = $clog2(MAX_ALLOCS + 1);

  state_t state, state_next;
  cell_ctl_t ctl;
  entry_t feed;
  entry_t ent [MAX_ALLOCS];
  logic [MAX_ALLOCS-1:0] gtv, holev, matchv, validv, pendv;

  logic [31:0] bb;
  logic [2:0] fdly;
  logic grow_en;
  logic [NB_W-1:0] active;
  logic [34:0] total;

  logic [1:0] q_cmd;
  logic [31:0] q_req, q_start;
  logic [BUF_W-1:0] q_buf;

  logic [NB_W-1:0] sb;
  logic [32:0] prev_end;
  logic srch_done, found;
  logic [31:0] where_off;
  logic [BUF_W-1:0] fbuf;
  logic [RW-1:0] rcnt;

  logic [2:0] res_status;
  logic [BUF_W-1:0] res_buf;
  logic [31:0] res_start;
  logic res_grew;
  logic [6:0] res_freed;

  entry_t head;
  logic hd_here, gap_ok, end_ok, rot_end, advance, packed_ok;
  logic grow_ok, do_place, release_hd, hit, hit_pend, load_out;
  logic [NB_W-1:0] sb_inc;
  logic [3:0] init_clamp;

  genvar gi;
  generate
    for (gi = 0; gi < MAX_ALLOCS; gi++) begin : g_cell
      entry_t pe, ne;
      logic pg, hi;
      if (gi == 0) begin : g_first
        assign pe = ctl.ent;
        assign pg = 1'b0;
        assign hi = 1'b0;
      end else begin : g_mid
        assign pe = ent[gi-1];
        assign pg = gtv[gi-1];
        assign hi = holev[gi-1];
      end
      if (gi == MAX_ALLOCS - 1) begin : g_last
        assign ne = feed;
      end else begin : g_inner
        assign ne = ent[gi+1];
      end
      ffsa_cell u_cell (
        .clk(clk), .rst(rst), .ctl(ctl),
        .prev_e(pe), .prev_gt(pg), .next_e(ne), .hole_in(hi),
        .ent(ent[gi]), .gt(gtv[gi]), .hole_out(holev[gi]), .match(matchv[gi])
      );
      assign validv[gi] = ent[gi].valid;
      assign pendv[gi] = ent[gi].pending;
    end
  endgenerate

  assign head = ent[0];
  assign hd_here = head.valid && ({1'b0, head.buf_idx} == sb);
  assign gap_ok = ({1'b0, head.off} >= prev_end) &&
                  (({1'b0, head.off} - prev_end) >= {1'b0, q_req});
  assign end_ok = ({1'b0, prev_end} + {2'b0, q_req}) <= {2'b0, bb};
  assign sb_inc = sb + 1'b1;
  assign rot_end = (rcnt == RW'(MAX_ALLOCS));
  assign advance = (state == S_SCAN) && !rot_end && (srch_done || (hd_here && !gap_ok));
  assign packed_ok = ~|(~validv[MAX_ALLOCS-2:0] & validv[MAX_ALLOCS-1:1]);
  assign grow_ok = !found && grow_en && (active < NB_W'(MAX_BUFFERS)) && (q_req <= bb);
  assign do_place = found || grow_ok;
  assign release_hd = head.valid && head.pending && (head.frames == 3'd0);
  assign hit = |matchv;
  assign hit_pend = |(matchv & pendv);
  assign load_out = (state == S_FINISH) && (!m_tvalid || m_tready);
  assign init_clamp = (cfg_data[3:0] == 4'd0) ? 4'd1 :
                      (cfg_data[3:0] > 4'(MAX_BUFFERS)) ? 4'(MAX_BUFFERS) : cfg_data[3:0];
  assign cfg_ready = 1'b1;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (s_tvalid) state_next = S_DISPATCH;
      S_DISPATCH: begin
        if (q_cmd == CMD_ALLOC && validv[MAX_ALLOCS-1] == 1'b0 && q_req != 32'd0)
          state_next = S_SCAN;
        else if (q_cmd == CMD_TICK) state_next = S_TICK;
        else state_next = S_FINISH;
      end
      S_SCAN: if (srch_done && rot_end) state_next = S_PLACE;
      S_PLACE: state_next = S_FINISH;
      S_TICK: if (rot_end) state_next = S_COMPACT;
      S_COMPACT: if (packed_ok) state_next = S_FINISH;
      S_FINISH: if (!m_tvalid || m_tready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // input ready and outputs to the cell row
  always_comb begin
    s_tready = (state == S_IDLE);
    ctl.op = C_HOLD;
    ctl.ent.valid = 1'b1;
    ctl.ent.pending = 1'b0;
    ctl.ent.frames = 3'd0;
    ctl.ent.buf_idx = found ? fbuf : active[BUF_W-1:0];
    ctl.ent.off = found ? where_off : 32'd0;
    ctl.ent.len = q_req;
    ctl.key_buf = q_buf;
    ctl.key_off = q_start;
    ctl.free_delay = fdly;
    feed = head;
    feed.valid = 1'b0;
    case (state)
      S_DISPATCH: begin
        if (q_cmd == CMD_FREE && hit && !hit_pend) ctl.op = C_MARK;
      end
      S_SCAN: begin
        if (advance) ctl.op = C_ROT;
        feed = head;
      end
      S_PLACE: if (do_place) ctl.op = C_INS;
      S_TICK: begin
        if (!rot_end) ctl.op = C_ROT;
        feed = head;
        if (head.valid && head.pending) begin
          if (release_hd) begin
            feed.valid = 1'b0;
            feed.pending = 1'b0;
          end else begin
            feed.frames = head.frames - 3'd1;
          end
        end
      end
      S_COMPACT: ctl.op = C_COMP;
      default: ctl.op = C_HOLD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      bb <= 32'd65536;
      fdly <= 3'd2;
      grow_en <= 1'b0;
      active <= NB_W'(1);
      total <= 35'd0;
      m_tvalid <= 1'b0;
      rcnt <= '0;
      srch_done <= 1'b0;
      found <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid) begin
        case (cfg_index)
          REG_INIT_BUFS: if (init_clamp > active) active <= init_clamp;
          REG_BUF_BYTES: bb <= cfg_data;
          REG_FREE_DLY: fdly <= cfg_data[2:0];
          REG_CAN_GROW: grow_en <= cfg_data[0];
          default: bb <= bb;
        endcase
      end
      if (advance || (state == S_TICK && !rot_end)) rcnt <= rcnt + 1'b1;
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            q_cmd <= s_tuser;
            q_req <= s_tdata[31:0];
            q_buf <= s_tdata[34:32];
            q_start <= s_tdata[66:35];
            res_status <= ST_OK;
            res_buf <= '0;
            res_start <= 32'd0;
            res_grew <= 1'b0;
            res_freed <= 7'd0;
          end
        end
        S_DISPATCH: begin
          rcnt <= '0;
          sb <= '0;
          prev_end <= 33'd0;
          srch_done <= 1'b0;
          found <= 1'b0;
          if (q_cmd == CMD_ALLOC) begin
            if (validv[MAX_ALLOCS-1]) res_status <= ST_FULL;
            else if (q_req == 32'd0) res_status <= ST_NO_SPACE;
          end else if (q_cmd == CMD_FREE) begin
            if (!hit) res_status <= ST_NOTFOUND;
            else if (hit_pend) res_status <= ST_PENDING;
          end
        end
        S_SCAN: begin
          if (!srch_done) begin
            if (hd_here) begin
              if (gap_ok) begin
                found <= 1'b1;
                srch_done <= 1'b1;
                where_off <= prev_end[31:0];
                fbuf <= sb[BUF_W-1:0];
              end else begin
                prev_end <= {1'b0, head.off} + {1'b0, head.len};
              end
            end else if (end_ok) begin
              found <= 1'b1;
              srch_done <= 1'b1;
              where_off <= prev_end[31:0];
              fbuf <= sb[BUF_W-1:0];
            end else begin
              sb <= sb_inc;
              prev_end <= 33'd0;
              if (sb_inc >= active) srch_done <= 1'b1;
            end
          end
        end
        S_PLACE: begin
          if (do_place) begin
            total <= total + {3'b0, q_req};
            res_buf <= ctl.ent.buf_idx;
            res_start <= ctl.ent.off;
            if (grow_ok) begin
              active <= active + 1'b1;
              res_grew <= 1'b1;
            end
          end else begin
            res_status <= ST_NO_SPACE;
          end
        end
        S_TICK: begin
          if (!rot_end && release_hd) begin
            total <= total - {3'b0, head.len};
            res_freed <= res_freed + 7'd1;
          end
        end
        default: rcnt <= rcnt;
      endcase
      if (load_out) begin
        m_tvalid <= 1'b1;
        m_tdata <= {7'd0, total, res_freed, res_grew, res_start, res_buf, res_status};
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  a_packed_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> packed_ok) else $error("table has a hole while idle");
  a_active_range: assert property (@(posedge clk) disable iff (rst)
    (active >= NB_W'(1)) && (active <= NB_W'(MAX_BUFFERS)))
    else $error("active buffer count out of range");
  a_out_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == S_FINISH))
    else $error("result shown without finishing");

endmodule

// File: hdl/ffsa_cell.sv
// one table cell: holds an allocation, shifts, inserts, compacts, matches and marks
module ffsa_cell (
  input  logic              clk,
  input  logic              rst,
  input  ffsa_pkg::cell_ctl_t ctl,
  input  ffsa_pkg::entry_t  prev_e,
  input  logic              prev_gt,
  input  ffsa_pkg::entry_t  next_e,
  input  logic              hole_in,
  output ffsa_pkg::entry_t  ent,
  output logic              gt,
  output logic              hole_out,
  output logic              match
);
  import ffsa_pkg::*;

  entry_t ent_next;

  assign gt = !ent.valid || ({ent.buf_idx, ent.off} > {ctl.ent.buf_idx, ctl.ent.off});
  assign hole_out = hole_in || !ent.valid;
  assign match = ent.valid && (ent.buf_idx == ctl.key_buf) && (ent.off == ctl.key_off);

  always_comb begin
    ent_next = ent;
    case (ctl.op)
      C_ROT: ent_next = next_e;
      C_INS: begin
        if (gt) ent_next = prev_gt ? prev_e : ctl.ent;
      end
      C_MARK: begin
        if (match) begin
          ent_next.pending = 1'b1;
          ent_next.frames = ctl.free_delay;
        end
      end
      C_COMP: begin
        if (hole_out) ent_next = next_e;
      end
      default: ent_next = ent;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ent.valid <= 1'b0;
      ent.pending <= 1'b0;
    end else begin
      ent <= ent_next;
    end
  end

endmodule

// File: sim/testbench.sv
// self-checking testbench for the first-fit sub-allocator with deferred free
`timescale 1ns / 1ps

module testbench;
  import ffsa_pkg::*;

  localparam int SLOTS = MAX_ALLOCS_DEF;
  localparam int CYCLE_LIMIT = 3000000;

  typedef struct packed {
    logic [2:0]  status;
    logic [2:0]  alloc_buffer;
    logic [31:0] alloc_start;
    logic        grew;
    logic [6:0]  freed_count;
    logic [34:0] in_use_bytes;
  } result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [71:0] s_tdata = '0;  // req_size, buf_index, start_req
  logic [1:0]  s_tuser = '0;  // cmd
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [87:0] m_tdata;  // status, alloc_buffer, alloc_start, grew, freed_count, in_use_bytes
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  first_fit_suballocator_deferred_free dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // allocator mirror
  longint unsigned buf_size = 65536;
  logic [2:0]      delay_reg = 3'd2;
  logic            grow_en = 1'b0;
  bit              slot_live [SLOTS];
  logic [2:0]      slot_buf [SLOTS];
  longint unsigned slot_off [SLOTS];
  longint unsigned slot_len [SLOTS];
  bit              slot_pend [SLOTS];
  logic [2:0]      slot_wait [SLOTS];
  int              active_bufs = 1;
  logic [34:0]     bytes_in_use = '0;

  result_t expected_q[$];
  int      errors = 0;
  int      beats_checked = 0;
  int      items_sent = 0;
  int      grow_events = 0;
  int      full_events = 0;
  int      released_total = 0;
  int      cycles = 0;
  int      gap_pct = 50;
  int      ready_pct = 70;
  int      hold_req = 0;
  int      hold_left = 0;
  int      stall_left = 0;

  function automatic bit first_gap(int b, longint unsigned req, output longint unsigned where);
    longint unsigned prev_end, last;
    bit have_last;
    int pick;
    prev_end = 0;
    last = 0;
    have_last = 0;
    where = 0;
    while (1) begin
      pick = -1;
      for (int k = 0; k < SLOTS; k++) begin
        if (!slot_live[k] || slot_buf[k] != b) continue;
        if (have_last && slot_off[k] <= last) continue;
        if (pick < 0 || slot_off[k] < slot_off[pick]) pick = k;
      end
      if (pick < 0) break;
      if (slot_off[pick] >= prev_end && slot_off[pick] - prev_end >= req) begin
        where = prev_end;
        return 1;
      end
      prev_end = slot_off[pick] + slot_len[pick];
      last = slot_off[pick];
      have_last = 1;
    end
    if (prev_end + req <= buf_size) begin
      where = prev_end;
      return 1;
    end
    return 0;
  endfunction

  function automatic result_t allocator_step(logic [1:0] cmd, logic [31:0] req,
                                             logic [2:0] bidx, logic [31:0] sreq);
    result_t r;
    int free_slot, hit, b;
    bit found;
    longint unsigned where;
    r = '0;
    found = 0;
    where = 0;
    b = 0;
    if (cmd == CMD_ALLOC) begin
      free_slot = -1;
      for (int k = 0; k < SLOTS; k++)
        if (!slot_live[k] && free_slot < 0) free_slot = k;
      if (free_slot < 0) begin
        r.status = ST_FULL;
        full_events++;
      end else if (req == 0) begin
        r.status = ST_NO_SPACE;
      end else begin
        for (b = 0; b < active_bufs; b++)
          if (first_gap(b, 64'(req), where)) begin
            found = 1;
            break;
          end
        if (!found && grow_en && active_bufs < MAX_BUFFERS && req <= buf_size) begin
          b = active_bufs;
          active_bufs++;
          where = 0;
          found = 1;
          r.grew = 1'b1;
          grow_events++;
        end
        if (found) begin
          slot_live[free_slot] = 1;
          slot_buf[free_slot] = b[2:0];
          slot_off[free_slot] = where;
          slot_len[free_slot] = 64'(req);
          slot_pend[free_slot] = 0;
          slot_wait[free_slot] = '0;
          bytes_in_use += 35'(req);
          r.alloc_buffer = b[2:0];
          r.alloc_start = where[31:0];
        end else begin
          r.status = ST_NO_SPACE;
        end
      end
    end else if (cmd == CMD_FREE) begin
      hit = -1;
      for (int k = 0; k < SLOTS; k++)
        if (hit < 0 && slot_live[k] && slot_buf[k] == bidx && slot_off[k] == sreq) hit = k;
      if (hit < 0) r.status = ST_NOTFOUND;
      else if (slot_pend[hit]) r.status = ST_PENDING;
      else begin
        slot_pend[hit] = 1;
        slot_wait[hit] = delay_reg;
      end
    end else if (cmd == CMD_TICK) begin
      for (int k = 0; k < SLOTS; k++) begin
        if (!slot_live[k] || !slot_pend[k]) continue;
        if (slot_wait[k] == 0) begin
          slot_live[k] = 0;
          slot_pend[k] = 0;
          bytes_in_use -= slot_len[k][34:0];
          r.freed_count++;
        end else begin
          slot_wait[k]--;
        end
      end
      released_total += r.freed_count;
    end
    r.in_use_bytes = bytes_in_use;
    return r;
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r >= gap_pct) return 0;
    if (r < gap_pct * 9 / 10) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic push_command(logic [1:0] cmd, logic [31:0] req, logic [2:0] bidx,
                              logic [31:0] sreq);
    int g;
    result_t exp_r;
    s_tvalid <= 1'b1;
    s_tuser <= cmd;
    s_tdata <= {5'b0, sreq, bidx, req};
    do @(posedge clk); while (!s_tready);
    exp_r = allocator_step(cmd, req, bidx, sreq);
    expected_q = {expected_q, exp_r};
    items_sent++;
    g = gap_len();
    if (g > 0) begin
      s_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_INIT_BUFS: begin
        if (value[3:0] > active_bufs)
          active_bufs = (value[3:0] > MAX_BUFFERS) ? MAX_BUFFERS : value[3:0];
      end
      REG_BUF_BYTES: buf_size = {32'd0, value};
      REG_FREE_DLY:  delay_reg = value[2:0];
      REG_CAN_GROW:  grow_en = value[0];
      default: ;
    endcase
  endtask

  task automatic free_live(bit any_live);
    int picks[$];
    int k;
    for (int i = 0; i < SLOTS; i++) if (slot_live[i]) picks = {picks, i};
    if (picks.size() == 0 || !any_live) begin
      push_command(CMD_FREE, $urandom, 3'($urandom_range(0, 7)), $urandom_range(0, 3) == 0 ?
                   $urandom : $urandom_range(0, 255));
    end else begin
      k = picks[$urandom_range(0, picks.size() - 1)];
      push_command(CMD_FREE, $urandom, slot_buf[k], slot_off[k][31:0]);
    end
  endtask

  function automatic logic [31:0] pick_size();
    int r;
    longint unsigned top;
    r = $urandom_range(0, 99);
    top = buf_size / 16;
    if (top == 0) top = 1;
    if (top > 32'hffff_ffff) top = 32'hffff_ffff;
    if (r < 70) return $urandom_range(1, 32'(top));
    if (r < 80) return $urandom_range(1, 32'(buf_size));
    if (r < 84) return 32'd0;
    if (r < 90) return $urandom;
    return 32'((buf_size > 4) ? buf_size - $urandom_range(0, 3) : buf_size);
  endfunction

  task automatic random_item();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) push_command(CMD_ALLOC, pick_size(), 3'($urandom), $urandom);
    else if (r < 80) free_live(r < 75);
    else if (r < 97) push_command(CMD_TICK, $urandom, 3'($urandom), $urandom);
    else push_command(2'd3, $urandom, 3'($urandom), $urandom);
  endtask

  task automatic drain_table();
    for (int i = 0; i < SLOTS; i++)
      if (slot_live[i] && !slot_pend[i])
        push_command(CMD_FREE, 32'd0, slot_buf[i], slot_off[i][31:0]);
    repeat (9) push_command(CMD_TICK, 32'd0, 3'd0, 32'd0);
  endtask

  task automatic test_directed();
    push_command(CMD_ALLOC, 32'd0, 3'd0, 32'd0);
    push_command(CMD_ALLOC, 32'd1, 3'd0, 32'd0);
    push_command(CMD_ALLOC, 32'd65536, 3'd0, 32'd0);
    push_command(CMD_ALLOC, 32'd100, 3'd0, 32'd0);
    push_command(CMD_ALLOC, 32'hffff_ffff, 3'd7, 32'hffff_ffff);
    push_command(CMD_FREE, 32'd0, 3'd7, 32'hffff_ffff);
    push_command(CMD_FREE, 32'd0, 3'd0, 32'd0);
    push_command(CMD_FREE, 32'd0, 3'd0, 32'd0);
    push_command(CMD_ALLOC, 32'd1, 3'd0, 32'd0);
    repeat (3) push_command(CMD_TICK, 32'd0, 3'd0, 32'd0);
    push_command(CMD_ALLOC, 32'd1, 3'd0, 32'd0);
    push_command(2'd3, 32'hffff_ffff, 3'd7, 32'hffff_ffff);
    push_command(CMD_ALLOC, 32'd65435, 3'd0, 32'd0);
    push_command(CMD_ALLOC, 32'd1, 3'd0, 32'd0);
    drain_table();
  endtask

  task automatic test_growth_and_full();
    write_reg(REG_INIT_BUFS, 32'd0);
    write_reg(REG_BUF_BYTES, 32'd1);
    write_reg(REG_FREE_DLY, 32'd0);
    write_reg(REG_CAN_GROW, 32'd1);
    repeat (10) push_command(CMD_ALLOC, 32'd1, 3'd0, 32'd0);
    push_command(CMD_ALLOC, 32'd2, 3'd0, 32'd0);
    drain_table();
    write_reg(REG_BUF_BYTES, 32'hffff_ffff);
    write_reg(REG_INIT_BUFS, 32'd15);
    repeat (66) push_command(CMD_ALLOC, $urandom_range(1, 4), 3'd0, 32'd0);
    drain_table();
    push_command(CMD_ALLOC, 32'hffff_ffff, 3'd0, 32'd0);
    push_command(CMD_ALLOC, 32'hffff_ffff, 3'd0, 32'd0);
    drain_table();
  endtask

  task automatic test_random();
    logic [31:0] sizes [5] = '{32'd4096, 32'd100, 32'hffff_ffff, 32'd65536, 32'd7};
    for (int p = 0; p < 5; p++) begin
      write_reg(REG_BUF_BYTES, p == 4 ? $urandom : sizes[p]);
      write_reg(REG_FREE_DLY, p == 1 ? 32'd7 : $urandom_range(0, 7));
      write_reg(REG_CAN_GROW, p % 2);
      gap_pct = (p == 2) ? 0 : 50;
      ready_pct = (p == 3) ? 100 : 70;
      repeat (120) random_item();
      drain_table();
    end
    gap_pct = 50;
    ready_pct = 70;
  endtask

  task automatic test_backpressure();
    hold_req = 400;
    repeat (30) random_item();
    wait_idle();
    repeat (20) random_item();
  endtask

  // result ready with random stalls and a long hold when asked
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("first_fit_suballocator_deferred_free: mismatch");
      $finish;
    end
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else begin
      if (ready_pct < 100 && $urandom_range(0, 99) == 0) stall_left = $urandom_range(20, 60);
      m_tready <= ($urandom_range(0, 99) < ready_pct);
    end
  end

  // result checker
  always @(posedge clk) begin
    result_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = {m_tdata[2:0], m_tdata[5:3], m_tdata[37:6], m_tdata[38], m_tdata[45:39],
             m_tdata[80:46]};
      beats_checked++;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected beat %h", got);
      end else begin
        want = expected_q.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10)
            $display("beat %0d: exp st=%0d buf=%0d start=%h grew=%0d freed=%0d used=%h | got st=%0d buf=%0d start=%h grew=%0d freed=%0d used=%h",
                     beats_checked, want.status, want.alloc_buffer, want.alloc_start,
                     want.grew, want.freed_count, want.in_use_bytes, got.status,
                     got.alloc_buffer, got.alloc_start, got.grew, got.freed_count,
                     got.in_use_bytes);
        end
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_growth_and_full();
    test_random();
    test_backpressure();
    wait_idle();
    $display("%0d commands, %0d results checked, %0d growth events, %0d table-full answers",
             items_sent, beats_checked, grow_events, full_events);
    $display("%0d deferred releases, %0d mismatches", released_total, errors);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("first_fit_suballocator_deferred_free: match");
    end else begin
      $display("first_fit_suballocator_deferred_free: mismatch");
    end
    $finish;
  end

endmodule

// File: first_fit_suballocator_deferred_free.f
hdl/ffsa_pkg.sv
hdl/ffsa_cell.sv
hdl/first_fit_suballocator_deferred_free.sv
sim/testbench.sv
